// ===== src/rbed_pkg.sv =====
// ----------------------------------------------------------------------------
// rbed_pkg
// Shared widths, defaults and types of the ray/box entry distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package rbed_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;                  // signed coordinate width
    localparam int HALF_W        = 31;                  // half-extent width
    localparam int THR_W         = 16;                  // parallel threshold width
    localparam int DMAG_W        = 32;                  // |dir| width
    localparam int BND_W         = 35;                  // slab bound / numerator width
    localparam int NMAG_W        = 33;                  // |numerator| width
    localparam int NAXES         = 3;
    localparam int NLANES        = 2 * NAXES;           // lower and upper slab per axis
    localparam int DIST_W        = 32;
    localparam int HALF_LSB      = 3 * NAXES * COORD_W; // first half-extent bit in tdata
    localparam int S_TDATA_W     = 384;
    localparam int M_TDATA_W     = 40;

    // sideband that travels beside the dividers
    typedef struct packed {
        logic [NAXES-1:0] par;   // axis counts as parallel
        logic             pmiss; // origin outside a parallel slab
    } rbed_side_t;

endpackage
`default_nettype wire

// ===== src/ray_box_entry_distance_top.sv =====
// ----------------------------------------------------------------------------
// ray_box_entry_distance_top
// Ray versus axis-aligned box slab test, streaming, one word per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one ray/box word per clock unless stalled and returns one result word per
// input word, in order. The pipeline is one front stage, one stage per quotient bit
// in the six-lane divider plus a sign stage, two merge stages and the output
// register. Throughput is one word per clock while m_axis_tready is high;
// when the output register is full and not taken, the whole pipeline holds.
// Write parallel_threshold only while the pipeline is empty.
`default_nettype none
module ray_box_entry_distance_top import rbed_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration: parallel_threshold
    input  wire logic                  cfg_we,
    input  wire logic [THR_W-1:0]      cfg_wdata,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // origin_x/y/z, dir_x/y/z, center_x/y/z (32 each), half_size_x/y/z (31 each), zero pad
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // hit (1), entry_distance (32), zero pad
    output logic [M_TDATA_W-1:0]       m_axis_tdata
);

    localparam int Q_W = NMAG_W + FRAC_BITS + 1;

    logic                  en;
    logic [THR_W-1:0]      thr_reg;
    logic signed [COORD_W-1:0] origin [NAXES];
    logic signed [COORD_W-1:0] dir    [NAXES];
    logic signed [COORD_W-1:0] center [NAXES];
    logic        [HALF_W-1:0]  half   [NAXES];

    logic                  p_valid;
    rbed_side_t            p_side;
    logic [NMAG_W-1:0]     p_mag [NLANES];
    logic                  p_neg [NLANES];
    logic [DMAG_W-1:0]     p_dsr [NLANES];

    logic                  d_valid;
    rbed_side_t            d_side;
    logic signed [Q_W-1:0] d_q [NLANES];

    logic                  r_valid, r_hit;
    logic [DIST_W-1:0]     r_dist;

    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;

    // advance everything unless the output word is stuck
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // unpack the input word
    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            origin[a] = s_axis_tdata[a*COORD_W +: COORD_W];
            dir[a]    = s_axis_tdata[(NAXES+a)*COORD_W +: COORD_W];
            center[a] = s_axis_tdata[(2*NAXES+a)*COORD_W +: COORD_W];
            half[a]   = s_axis_tdata[HALF_LSB + a*HALF_W +: HALF_W];
        end
    end

    rbed_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .origin    (origin),
        .dir       (dir),
        .center    (center),
        .half      (half),
        .thr       (thr_reg),
        .out_valid (p_valid),
        .out_side  (p_side),
        .out_mag   (p_mag),
        .out_neg   (p_neg),
        .out_dsr   (p_dsr)
    );

    rbed_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p_valid),
        .in_side   (p_side),
        .in_mag    (p_mag),
        .in_neg    (p_neg),
        .in_dsr    (p_dsr),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_q     (d_q)
    );

    rbed_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .in_q      (d_q),
        .out_valid (r_valid),
        .out_hit   (r_hit),
        .out_dist  (r_dist)
    );

    // output register: hold while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {{(M_TDATA_W-DIST_W-1){1'b0}}, r_dist, r_hit};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // a miss always reports zero distance
    a_miss_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[DIST_W:1] == '0))
        else $error("miss with nonzero distance");

    // input is taken exactly when the output stage can move
    a_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output stage");

    // no result in the cycle after a reset edge
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // threshold write lands
    a_cfg : assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cfg_we && aresetn) |-> (thr_reg == $past(cfg_wdata)))
        else $error("threshold write lost");

endmodule
`default_nettype wire

// ===== src/rbed_prep.sv =====
// ----------------------------------------------------------------------------
// rbed_prep
// Front stage: slab bounds, numerators, magnitudes, signs, parallel test.
// ----------------------------------------------------------------------------
`default_nettype none
module rbed_prep import rbed_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic signed [COORD_W-1:0] origin [NAXES],
    input  wire logic signed [COORD_W-1:0] dir    [NAXES],
    input  wire logic signed [COORD_W-1:0] center [NAXES],
    input  wire logic        [HALF_W-1:0]  half   [NAXES],
    input  wire logic        [THR_W-1:0]   thr,
    output logic                          out_valid,
    output rbed_side_t                    out_side,
    output logic        [NMAG_W-1:0]      out_mag [NLANES],
    output logic                          out_neg [NLANES],
    output logic        [DMAG_W-1:0]      out_dsr [NLANES]
);

    logic               valid_reg;
    rbed_side_t         side_reg, side_next;
    logic [NMAG_W-1:0]  mag_reg [NLANES];
    logic [NMAG_W-1:0]  mag_next [NLANES];
    logic               neg_reg [NLANES];
    logic               neg_next [NLANES];
    logic [DMAG_W-1:0]  dsr_reg [NLANES];
    logic [DMAG_W-1:0]  dsr_next [NLANES];

    always_comb begin
        logic signed [BND_W-1:0] o, lo, hi, n0, n1;
        logic        [DMAG_W-1:0] dm;
        logic        [BND_W-1:0]  m0, m1;
        side_next = '0;
        for (int a = 0; a < NAXES; a++) begin
            o  = BND_W'(origin[a]);
            lo = BND_W'(center[a]) - $signed({{(BND_W-HALF_W){1'b0}}, half[a]});
            hi = BND_W'(center[a]) + $signed({{(BND_W-HALF_W){1'b0}}, half[a]});
            n0 = lo - o;
            n1 = hi - o;
            m0 = n0[BND_W-1] ? BND_W'(-n0) : BND_W'(n0);
            m1 = n1[BND_W-1] ? BND_W'(-n1) : BND_W'(n1);
            dm = dir[a][COORD_W-1] ? DMAG_W'(-dir[a]) : DMAG_W'(dir[a]);
            side_next.par[a] = (dm <= {{(DMAG_W-THR_W){1'b0}}, thr});
            if (side_next.par[a] && ((o < lo) || (o > hi))) begin
                side_next.pmiss = 1'b1;
            end
            mag_next[2*a]   = m0[NMAG_W-1:0];
            mag_next[2*a+1] = m1[NMAG_W-1:0];
            neg_next[2*a]   = n0[BND_W-1] ^ dir[a][COORD_W-1];
            neg_next[2*a+1] = n1[BND_W-1] ^ dir[a][COORD_W-1];
            dsr_next[2*a]   = dm;
            dsr_next[2*a+1] = dm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            dsr_reg  <= dsr_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;
    assign out_dsr   = dsr_reg;

endmodule
`default_nettype wire

// ===== src/rbed_div.sv =====
// ----------------------------------------------------------------------------
// rbed_div
// Six-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rbed_div import rbed_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire rbed_side_t                    in_side,
    input  wire logic        [NMAG_W-1:0]      in_mag [NLANES],
    input  wire logic                          in_neg [NLANES],
    input  wire logic        [DMAG_W-1:0]      in_dsr [NLANES],
    output logic                               out_valid,
    output rbed_side_t                         out_side,
    output logic signed [NMAG_W+FRAC_BITS:0]   out_q [NLANES]
);

    localparam int DVD_W = NMAG_W + FRAC_BITS;
    localparam int Q_W   = DVD_W + 1;
    localparam int ACC_W = DMAG_W + DVD_W;   // remainder above dividend/quotient

    logic       vld_reg  [1:DVD_W];
    rbed_side_t side_reg [1:DVD_W];
    logic       q_valid_reg;
    rbed_side_t q_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= DVD_W; s++) begin
                vld_reg[s] <= 1'b0;
            end
            q_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[1] <= in_valid;
            for (int s = 2; s <= DVD_W; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
            q_valid_reg <= vld_reg[DVD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[1] <= in_side;
            for (int s = 2; s <= DVD_W; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
            q_side_reg <= side_reg[DVD_W];
        end
    end

    for (genvar l = 0; l < NLANES; l++) begin : g_lane
        logic [ACC_W-1:0]  acc_reg [1:DVD_W];
        logic [DMAG_W-1:0] dsr_reg [1:DVD_W];
        logic              neg_reg [1:DVD_W];
        logic signed [Q_W-1:0] q_reg;

        for (genvar s = 1; s <= DVD_W; s++) begin : g_stage
            logic [ACC_W-1:0]  prev;
            logic [DMAG_W-1:0] dsr;
            logic              neg;
            logic [DMAG_W:0]   top, diff;
            logic              ge;
            logic [ACC_W-1:0]  acc_next;

            if (s == 1) begin : g_load
                assign prev = {{DMAG_W{1'b0}}, in_mag[l], {FRAC_BITS{1'b0}}};
                assign dsr  = in_dsr[l];
                assign neg  = in_neg[l];
            end else begin : g_chain
                assign prev = acc_reg[s-1];
                assign dsr  = dsr_reg[s-1];
                assign neg  = neg_reg[s-1];
            end

            always_comb begin
                top  = prev[ACC_W-1:DVD_W-1];
                diff = top - {1'b0, dsr};
                ge   = (top >= {1'b0, dsr});
                acc_next = {(ge ? diff[DMAG_W-1:0] : top[DMAG_W-1:0]),
                            prev[DVD_W-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    acc_reg[s] <= acc_next;
                    dsr_reg[s] <= dsr;
                    neg_reg[s] <= neg;
                end
            end
        end

        // apply the sign to the magnitude quotient
        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg <= neg_reg[DVD_W] ? -$signed({1'b0, acc_reg[DVD_W][DVD_W-1:0]})
                                        :  $signed({1'b0, acc_reg[DVD_W][DVD_W-1:0]});
            end
        end

        assign out_q[l] = q_reg;
    end

    assign out_valid = q_valid_reg;
    assign out_side  = q_side_reg;

endmodule
`default_nettype wire

// ===== src/rbed_merge.sv =====
// ----------------------------------------------------------------------------
// rbed_merge
// Order slab parameters, fold entry/exit bounds, decide hit and saturate.
// ----------------------------------------------------------------------------
`default_nettype none
module rbed_merge import rbed_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire rbed_side_t                    in_side,
    input  wire logic signed [NMAG_W+FRAC_BITS:0] in_q [NLANES],
    output logic                               out_valid,
    output logic                               out_hit,
    output logic [DIST_W-1:0]                  out_dist
);

    localparam int Q_W = NMAG_W + FRAC_BITS + 1;
    localparam logic signed [Q_W-1:0] T_MAX = {1'b0, {(Q_W-1){1'b1}}};

    logic                  a_valid_reg, b_valid_reg;
    logic                  a_pmiss_reg, b_pmiss_reg;
    logic signed [Q_W-1:0] near_reg [NAXES];
    logic signed [Q_W-1:0] far_reg  [NAXES];
    logic signed [Q_W-1:0] near_next [NAXES];
    logic signed [Q_W-1:0] far_next  [NAXES];
    logic signed [Q_W-1:0] entry_reg, exit_reg, entry_next, exit_next;

    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            if (in_side.par[a]) begin
                near_next[a] = '0;
                far_next[a]  = T_MAX;
            end else if (in_q[2*a] > in_q[2*a+1]) begin
                near_next[a] = in_q[2*a+1];
                far_next[a]  = in_q[2*a];
            end else begin
                near_next[a] = in_q[2*a];
                far_next[a]  = in_q[2*a+1];
            end
        end
    end

    always_comb begin
        entry_next = '0;
        exit_next  = T_MAX;
        for (int a = 0; a < NAXES; a++) begin
            if (near_reg[a] > entry_next) begin
                entry_next = near_reg[a];
            end
            if (far_reg[a] < exit_next) begin
                exit_next = far_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_pmiss_reg <= in_side.pmiss;
            near_reg    <= near_next;
            far_reg     <= far_next;
            b_pmiss_reg <= a_pmiss_reg;
            entry_reg   <= entry_next;
            exit_reg    <= exit_next;
        end
    end

    // entry is never negative, so the upper bits alone decide saturation
    assign out_valid = b_valid_reg;
    assign out_hit   = !b_pmiss_reg && (entry_reg <= exit_reg);
    assign out_dist  = !out_hit ? '0 :
                       (|entry_reg[Q_W-1:DIST_W]) ? {DIST_W{1'b1}} : entry_reg[DIST_W-1:0];

endmodule
`default_nettype wire
